/* src/sgi_pkg.sv */
// ----------------------------------------------------------------------------
// sgi_pkg
// Shared types and constants of the sensor gap interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package sgi_pkg;

    localparam int DATA_W          = 8;
    localparam int QUO_W           = 8;
    localparam int MAX_GAP_DEF     = 32;
    localparam int MAX_SAMPLES_DEF = 65535;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_MAX_VALID    = 1'b0;
    localparam logic REG_ZERO_INVALID = 1'b1;

    localparam logic [DATA_W-1:0] MAX_VALID_RST    = 8'd206;
    localparam logic              ZERO_INVALID_RST = 1'b1;

    localparam int OUT_TDATA_W = 3 * DATA_W;
    localparam int OUT_TUSER_W = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_INT_START,
        ST_INT_WAIT,
        ST_INT_EMIT,
        ST_FL_READ,
        ST_FL_EMIT,
        ST_S_EMIT,
        ST_LAST_STAT,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_LAST_EMIT
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              run_end;
        logic              stream_end;
        logic [DATA_W-1:0] max_value;
        logic [DATA_W-1:0] average;
        logic              repaired;
        logic              gap_overflow;
    } t_beat;

endpackage

`default_nettype wire

/* src/sgi_gap_mem.sv */
// ----------------------------------------------------------------------------
// sgi_gap_mem
// Store for held gap samples: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_gap_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic [AW-1:0]             i_wr_addr,
    input  wire logic [sgi_pkg::DATA_W-1:0] i_wr_data,
    input  wire logic                      i_rd_en,
    input  wire logic [AW-1:0]             i_rd_addr,
    output logic [sgi_pkg::DATA_W-1:0]     o_rd_data
);
    import sgi_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* src/sgi_divider.sv */
// ----------------------------------------------------------------------------
// sgi_divider
// Shift-and-subtract divider, one quotient bit per cycle, for quotients that
// fit in QUO_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_divider #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [NUM_W-1:0]         i_num,
    input  wire logic [DEN_W-1:0]         i_den,
    output logic                          o_done,
    output logic [sgi_pkg::QUO_W-1:0]     o_quo
);
    import sgi_pkg::*;

    localparam int RW  = (DEN_W + QUO_W - 1 > NUM_W) ? DEN_W + QUO_W - 1 : NUM_W;
    localparam int SCW = $clog2(QUO_W);

    logic [RW-1:0]    r_rem;
    logic [RW-1:0]    r_dsh;
    logic [QUO_W-1:0] r_quo;
    logic [SCW-1:0]   r_step;
    logic             r_busy;
    logic             r_done;
    logic             ge;

    assign ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= SCW'(QUO_W - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= RW'(i_num);
            r_dsh <= RW'(i_den) << (QUO_W - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[QUO_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

/* src/sgi_core.sv */
// ----------------------------------------------------------------------------
// sgi_core
// Sequencer: classifies samples, holds gaps, walks interpolation through the
// shared divider and raw flushes through the gap store, keeps statistics, drives output beats.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_core #(
    parameter int MAX_GAP     = sgi_pkg::MAX_GAP_DEF,
    parameter int MAX_SAMPLES = sgi_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [sgi_pkg::DATA_W-1:0] i_max_valid,
    input  wire logic                       i_zero_invalid,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [sgi_pkg::DATA_W-1:0] i_sample,
    input  wire logic                       i_final,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output sgi_pkg::t_beat                  o_out
);
    import sgi_pkg::*;

    localparam int GCW = $clog2(MAX_GAP + 1);
    localparam int AW  = (MAX_GAP > 1) ? $clog2(MAX_GAP) : 1;
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SW  = CW + DATA_W;
    localparam int PW  = DATA_W + GCW;
    localparam int DNW = (SW > PW) ? SW : PW;
    localparam int DDW = (CW > GCW + 1) ? CW : GCW + 1;

    t_state            r_state, n_state;
    logic [DATA_W-1:0] r_sample, n_sample;
    logic              r_fin, n_fin;
    logic              r_bad, n_bad;
    logic [DATA_W-1:0] r_anchor, n_anchor;
    logic              r_anchor_ok, n_anchor_ok;
    logic              r_in_gap, n_in_gap;
    logic [GCW-1:0]    r_gc, n_gc;
    logic [GCW-1:0]    r_idx, n_idx;
    logic [PW-1:0]     r_prod, n_prod;
    logic              r_neg, n_neg;
    logic [DATA_W-1:0] r_mag, n_mag;
    logic              r_ovf, n_ovf;
    logic [DATA_W-1:0] r_max, n_max;
    logic [SW-1:0]     r_sum, n_sum;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_repaired, n_repaired;
    logic              r_out_valid, n_out_valid;
    t_beat             r_out, n_out;

    logic              out_free;
    logic              mem_we;
    logic              mem_re;
    logic [DATA_W-1:0] mem_rdata;
    logic              div_start;
    logic [DNW-1:0]    div_num;
    logic [DDW-1:0]    div_den;
    logic              div_done;
    logic [QUO_W-1:0]  div_quo;
    logic              e_fire;
    logic [DATA_W-1:0] e_val;
    logic              e_ovf;
    logic              e_run_end;
    logic              e_final;
    logic              st_en;

    sgi_gap_mem #(
        .DEPTH (MAX_GAP),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_gc[AW-1:0]),
        .i_wr_data (r_sample),
        .i_rd_en   (mem_re),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (mem_rdata)
    );

    sgi_divider #(
        .NUM_W (DNW),
        .DEN_W (DDW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_sample    = r_sample;
        n_fin       = r_fin;
        n_bad       = r_bad;
        n_anchor    = r_anchor;
        n_anchor_ok = r_anchor_ok;
        n_in_gap    = r_in_gap;
        n_gc        = r_gc;
        n_idx       = r_idx;
        n_prod      = r_prod;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_ovf       = r_ovf;
        n_max       = r_max;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_repaired  = r_repaired;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        div_start   = 1'b0;
        div_num     = DNW'(r_prod);
        div_den     = DDW'(r_gc) + DDW'(1);
        e_fire      = 1'b0;
        e_val       = r_sample;
        e_ovf       = 1'b0;
        e_run_end   = 1'b0;
        e_final     = 1'b0;
        st_en       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_sample = i_sample;
                    n_fin    = i_final;
                    n_bad    = (i_sample > i_max_valid) ||
                               (i_zero_invalid && (i_sample == '0));
                    n_state  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_idx = '0;
                n_ovf = 1'b0;
                if (!r_bad) begin
                    n_in_gap = 1'b0;
                    if (r_in_gap) begin
                        n_repaired = 1'b1;
                    end
                    n_neg = (r_sample < r_anchor);
                    n_mag = (r_sample < r_anchor) ? r_anchor - r_sample
                                                  : r_sample - r_anchor;
                    n_prod = (r_sample < r_anchor) ? PW'(r_anchor - r_sample)
                                                   : PW'(r_sample - r_anchor);
                    if (r_in_gap && r_anchor_ok && (r_gc != '0)) begin
                        n_idx   = GCW'(1);
                        n_state = ST_INT_START;
                    end else begin
                        n_gc    = '0;
                        n_state = ST_S_EMIT;
                    end
                end else begin
                    n_in_gap = 1'b1;
                    if (!r_anchor_ok) begin
                        n_state = ST_S_EMIT;
                    end else if (r_gc == GCW'(MAX_GAP)) begin
                        n_ovf       = 1'b1;
                        n_anchor_ok = 1'b0;
                        n_state     = ST_FL_READ;
                    end else if (r_fin) begin
                        n_state = (r_gc != '0) ? ST_FL_READ : ST_S_EMIT;
                    end else begin
                        mem_we  = 1'b1;
                        n_gc    = r_gc + 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_INT_START: begin
                div_start = 1'b1;
                n_state   = ST_INT_WAIT;
            end
            ST_INT_WAIT: begin
                if (div_done) begin
                    n_state = ST_INT_EMIT;
                end
            end
            ST_INT_EMIT: begin
                e_val = r_neg ? r_anchor - div_quo : r_anchor + div_quo;
                if (out_free) begin
                    e_fire = 1'b1;
                    st_en  = 1'b1;
                    if (r_idx == r_gc) begin
                        n_gc    = '0;
                        n_state = ST_S_EMIT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_prod  = r_prod + PW'(r_mag);
                        n_state = ST_INT_START;
                    end
                end
            end
            ST_FL_READ: begin
                mem_re  = 1'b1;
                n_state = ST_FL_EMIT;
            end
            ST_FL_EMIT: begin
                e_val = mem_rdata;
                e_ovf = r_ovf;
                if (out_free) begin
                    e_fire = 1'b1;
                    st_en  = 1'b1;
                    if (r_idx + 1'b1 == r_gc) begin
                        n_gc    = '0;
                        n_state = ST_S_EMIT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_FL_READ;
                    end
                end
            end
            ST_S_EMIT: begin
                e_ovf     = r_ovf;
                e_run_end = 1'b1;
                if (r_fin) begin
                    n_state = ST_LAST_STAT;
                end else if (out_free) begin
                    e_fire = 1'b1;
                    st_en  = 1'b1;
                    if (!r_bad) begin
                        n_anchor    = r_sample;
                        n_anchor_ok = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_LAST_STAT: begin
                st_en   = 1'b1;
                n_state = ST_AVG_START;
            end
            ST_AVG_START: begin
                div_start = 1'b1;
                div_num   = DNW'(r_sum);
                div_den   = DDW'(r_cnt);
                n_state   = ST_AVG_WAIT;
            end
            ST_AVG_WAIT: begin
                if (div_done) begin
                    n_state = ST_LAST_EMIT;
                end
            end
            ST_LAST_EMIT: begin
                e_ovf     = r_ovf;
                e_run_end = 1'b1;
                e_final   = 1'b1;
                if (out_free) begin
                    e_fire      = 1'b1;
                    n_anchor    = '0;
                    n_anchor_ok = 1'b0;
                    n_in_gap    = 1'b0;
                    n_gc        = '0;
                    n_max       = '0;
                    n_sum       = '0;
                    n_cnt       = '0;
                    n_repaired  = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (e_fire) begin
            n_out_valid        = 1'b1;
            n_out.value        = e_val;
            n_out.run_end      = e_run_end;
            n_out.stream_end   = e_final;
            n_out.gap_overflow = e_ovf;
            n_out.max_value    = e_final ? r_max : '0;
            n_out.average      = (e_final && (r_cnt != '0)) ? div_quo : '0;
            n_out.repaired     = e_final && r_repaired;
        end

        if (st_en) begin
            if (e_val > r_max) begin
                n_max = e_val;
            end
            if ((e_val != '0) && (r_cnt < CW'(MAX_SAMPLES))) begin
                n_sum = r_sum + SW'(e_val);
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_anchor_ok <= 1'b0;
            r_in_gap    <= 1'b0;
            r_gc        <= '0;
            r_max       <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_repaired  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_anchor_ok <= n_anchor_ok;
            r_in_gap    <= n_in_gap;
            r_gc        <= n_gc;
            r_max       <= n_max;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_repaired  <= n_repaired;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_fin    <= n_fin;
        r_bad    <= n_bad;
        r_anchor <= n_anchor;
        r_idx    <= n_idx;
        r_prod   <= n_prod;
        r_neg    <= n_neg;
        r_mag    <= n_mag;
        r_ovf    <= n_ovf;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

/* src/sensor_gap_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// sensor_gap_interpolator_unit
// Repairs gaps in an 8-bit sensor stream by linear interpolation and reports
// recording statistics on the last beat.
// ----------------------------------------------------------------------------
// An input beat is taken only while the sequencer is idle; a finished output
// beat waiting in the output register does not block it. A valid sample with
// no pending gap passes the decide and emit states; an invalid sample that is
// held passes the decide state only. Each held sample rewritten by
// interpolation takes a start, a wait and an emit state, the wait set by the
// one-bit-per-cycle divider; each raw flushed sample takes a read and an emit
// state, set by the registered read port of the gap store. The final sample of
// a recording adds the average division. Output stalls hold the emit states.
`default_nettype none

module sensor_gap_interpolator_unit #(
    parameter int MAX_GAP     = sgi_pkg::MAX_GAP_DEF,
    parameter int MAX_SAMPLES = sgi_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sgi_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [sgi_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sgi_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [sgi_pkg::DATA_W-1:0]      s_axis_tdata,  // sample
    input  wire logic                            s_axis_tlast,  // final_sample
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [sgi_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // value, max_value, average
    output logic                                 m_axis_tlast,  // run_end
    output logic [sgi_pkg::OUT_TUSER_W-1:0]      m_axis_tuser   // stream_end, repaired,
                                                                 // gap_overflow
);
    import sgi_pkg::*;

    logic [DATA_W-1:0] r_max_valid;
    logic              r_zero_invalid;
    logic              cfg_wr;
    logic              reg_idx;
    t_beat             out_beat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_valid    <= MAX_VALID_RST;
            r_zero_invalid <= ZERO_INVALID_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MAX_VALID:    r_max_valid    <= pwdata[DATA_W-1:0];
                REG_ZERO_INVALID: r_zero_invalid <= pwdata[0];
                default:          r_max_valid    <= r_max_valid;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MAX_VALID:    prdata = APB_DATA_W'(r_max_valid);
            REG_ZERO_INVALID: prdata = APB_DATA_W'(r_zero_invalid);
            default:          prdata = '0;
        endcase
    end

    sgi_core #(
        .MAX_GAP     (MAX_GAP),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_max_valid    (r_max_valid),
        .i_zero_invalid (r_zero_invalid),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_sample       (s_axis_tdata),
        .i_final        (s_axis_tlast),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out          (out_beat)
    );

    assign m_axis_tdata = {out_beat.average, out_beat.max_value, out_beat.value};
    assign m_axis_tlast = out_beat.run_end;
    assign m_axis_tuser = {out_beat.gap_overflow, out_beat.repaired, out_beat.stream_end};

endmodule

`default_nettype wire

/* src/sgi_checker.sv */
// ----------------------------------------------------------------------------
// sgi_checker
// Port-level checks on the output stream of the gap interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [sgi_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                            m_axis_tlast,
    input wire logic [sgi_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import sgi_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed while stalled");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("stream end beat without run end");

    a_stats_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            (m_axis_tdata[OUT_TDATA_W-1:DATA_W] == '0) && !m_axis_tuser[1])
        else $error("statistics present outside stream end beat");

    a_avg_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[3*DATA_W-1:2*DATA_W] <= m_axis_tdata[2*DATA_W-1:DATA_W])
        else $error("average above maximum");

endmodule

bind sensor_gap_interpolator_unit sgi_checker u_sgi_checker (.*);

`default_nettype wire

/* test/gap_repair_checker.sv */
// ----------------------------------------------------------------------------
// gap_repair_checker
// Watches the register port and both sample streams of the sensor gap
// interpolator. Each accepted input beat is run through a local model of the
// gap repair: anchor tracking, held-gap interpolation, raw flushes and
// recording statistics. The cleaned beats it predicts are queued, and every
// output beat is compared field by field against the oldest one in the queue.
// ----------------------------------------------------------------------------
module gap_repair_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_psel,
    input  wire logic                             i_penable,
    input  wire logic                             i_pwrite,
    input  wire logic                             i_pready,
    input  wire logic [sgi_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  wire logic [sgi_pkg::APB_DATA_W-1:0]   i_pwdata,
    input  wire logic                             i_in_valid,
    input  wire logic                             i_in_ready,
    input  wire logic [sgi_pkg::DATA_W-1:0]       i_in_data,  // sample
    input  wire logic                             i_in_last,  // final_sample
    input  wire logic                             i_out_valid,
    input  wire logic                             i_out_ready,
    input  wire logic [sgi_pkg::OUT_TDATA_W-1:0]  i_out_data, // value, max_value, average
    input  wire logic                             i_out_last, // run_end
    input  wire logic [sgi_pkg::OUT_TUSER_W-1:0]  i_out_user, // stream_end, repaired,
                                                              // gap_overflow
    output int                                    o_mismatches,
    output int                                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [sgi_pkg::APB_ADDR_W-1:0] ADDR_MAX_VALID    = {sgi_pkg::REG_MAX_VALID, 2'b00};
    localparam logic [sgi_pkg::APB_ADDR_W-1:0] ADDR_ZERO_INVALID =
        {sgi_pkg::REG_ZERO_INVALID, 2'b00};

    logic [7:0]     max_valid_reg;
    logic           zero_invalid_reg;
    logic [7:0]     anchor;
    logic           has_anchor;
    logic           gap_open;
    int             held_count;
    logic [7:0]     held [sgi_pkg::MAX_GAP_DEF];
    logic [7:0]     peak;
    int unsigned    positive_total;
    int unsigned    positive_seen;
    logic           repaired_seen;
    int             mismatch_count = 0;

    sgi_pkg::t_beat pending_cleaned[$];
    sgi_pkg::t_beat step_cleaned[$];

    assign o_mismatches = mismatch_count;

    task automatic clear_recording();
        anchor         = '0;
        has_anchor     = 1'b0;
        gap_open       = 1'b0;
        held_count     = 0;
        peak           = '0;
        positive_total = 0;
        positive_seen  = 0;
        repaired_seen  = 1'b0;
    endtask

    task automatic send_cleaned(input logic [7:0] v, input logic ovf);
        sgi_pkg::t_beat b;
        b              = '0;
        b.value        = v;
        b.gap_overflow = ovf;
        step_cleaned.push_back(b);
        if (v > peak) begin
            peak = v;
        end
        if (v != 8'd0 && positive_seen < sgi_pkg::MAX_SAMPLES_DEF) begin
            positive_total += v;
            positive_seen++;
        end
    endtask

    task automatic flush_held(input logic ovf);
        int k;
        for (k = 0; k < held_count; k++) begin
            send_cleaned(held[k], ovf);
        end
        held_count = 0;
    endtask

    task automatic clean_sample(input logic [7:0] s, input logic fin);
        logic           bad;
        int             span;
        int             steps;
        int             k;
        sgi_pkg::t_beat b;
        bad = (s > max_valid_reg) || (zero_invalid_reg && s == 8'd0);
        step_cleaned.delete();
        if (!bad) begin
            if (gap_open) begin
                repaired_seen = 1'b1;
                if (has_anchor) begin
                    span  = int'(s) - int'(anchor);
                    steps = held_count + 1;
                    for (k = 1; k <= held_count; k++) begin
                        send_cleaned(8'(int'(anchor) + span * k / steps), 1'b0);
                    end
                end
                held_count = 0;
                gap_open   = 1'b0;
            end
            send_cleaned(s, 1'b0);
            anchor     = s;
            has_anchor = 1'b1;
        end else begin
            gap_open = 1'b1;
            if (has_anchor) begin
                if (held_count < sgi_pkg::MAX_GAP_DEF) begin
                    held[held_count] = s;
                    held_count++;
                end else begin
                    flush_held(1'b1);
                    send_cleaned(s, 1'b1);
                    has_anchor = 1'b0;
                end
            end else begin
                send_cleaned(s, 1'b0);
            end
        end
        if (fin) begin
            flush_held(1'b0);
            if (step_cleaned.size() != 0) begin
                b            = step_cleaned.pop_back();
                b.stream_end = 1'b1;
                b.max_value  = peak;
                b.average    = (positive_seen != 0) ? 8'(positive_total / positive_seen) : 8'd0;
                b.repaired   = repaired_seen;
                step_cleaned.push_back(b);
            end
            clear_recording();
        end
        if (step_cleaned.size() != 0) begin
            b         = step_cleaned.pop_back();
            b.run_end = 1'b1;
            step_cleaned.push_back(b);
        end
        while (step_cleaned.size() != 0) begin
            pending_cleaned.push_back(step_cleaned.pop_front());
        end
    endtask

    task automatic flag_mismatch(input string field, input int got, input int want);
        $display("%0t: cleaned beat %s mismatch, got %0d expected %0d",
                 $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic check_result();
        sgi_pkg::t_beat got;
        sgi_pkg::t_beat want;
        got.value        = i_out_data[7:0];
        got.max_value    = i_out_data[15:8];
        got.average      = i_out_data[23:16];
        got.run_end      = i_out_last;
        got.stream_end   = i_out_user[0];
        got.repaired     = i_out_user[1];
        got.gap_overflow = i_out_user[2];
        if (pending_cleaned.size() == 0) begin
            flag_mismatch("unexpected", got.value, 0);
            return;
        end
        want = pending_cleaned.pop_front();
        if (got.value != want.value)
            flag_mismatch("value", got.value, want.value);
        if (got.run_end != want.run_end)
            flag_mismatch("run_end", got.run_end, want.run_end);
        if (got.stream_end != want.stream_end)
            flag_mismatch("stream_end", got.stream_end, want.stream_end);
        if (got.max_value != want.max_value)
            flag_mismatch("max_value", got.max_value, want.max_value);
        if (got.average != want.average)
            flag_mismatch("average", got.average, want.average);
        if (got.repaired != want.repaired)
            flag_mismatch("repaired", got.repaired, want.repaired);
        if (got.gap_overflow != want.gap_overflow)
            flag_mismatch("gap_overflow", got.gap_overflow, want.gap_overflow);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_valid_reg    = sgi_pkg::MAX_VALID_RST;
            zero_invalid_reg = sgi_pkg::ZERO_INVALID_RST;
            clear_recording();
            pending_cleaned.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == ADDR_MAX_VALID) begin
                    max_valid_reg = i_pwdata[7:0];
                end else if (i_paddr == ADDR_ZERO_INVALID) begin
                    zero_invalid_reg = i_pwdata[0];
                end
            end
            if (i_in_valid && i_in_ready) begin
                clean_sample(i_in_data, i_in_last);
            end
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
        end
        o_pending <= pending_cleaned.size();
    end

endmodule

/* test/tb_sensor_gap_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// tb_sensor_gap_interpolator_unit
// Drives the sensor gap interpolator with a directed set of edge cases and
// then with random recordings (valid runs, short and overlong gaps, trailing
// runs, noise) under several register settings, with random idling on both
// streams, one long output hold-off and pauses until the output drains. A
// separate checker predicts and compares every output beat.
// ----------------------------------------------------------------------------
module tb_sensor_gap_interpolator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sgi_pkg::*;

    localparam int LIMIT_CYCLES     = 3000000;
    localparam int SETTLE_CYCLES    = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS      = 20;

    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_VALID    = {REG_MAX_VALID, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_ZERO_INVALID = {REG_ZERO_INVALID, 2'b00};

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata;   // sample
    logic                   s_axis_tlast;   // final_sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // value, max_value, average
    logic                   m_axis_tlast;   // run_end
    logic [OUT_TUSER_W-1:0] m_axis_tuser;   // stream_end, repaired, gap_overflow

    int         mismatches;
    int         pending_results;
    int         cycles;
    logic [7:0] cfg_max_valid;
    logic       cfg_zero_invalid;
    bit         long_hold_req = 1'b0;
    bit         rx_quiet      = 1'b0;
    bit         tx_quiet      = 1'b0;

    sensor_gap_interpolator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    gap_repair_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .i_out_user   (m_axis_tuser),
        .o_mismatches (mismatches),
        .o_pending    (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[sensor_gap_interpolator_unit] ERROR");
        $finish;
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [7:0] pick_valid();
        int lo;
        lo = cfg_zero_invalid ? 1 : 0;
        if (lo > cfg_max_valid) return 8'($urandom_range(255, 0));
        if ($urandom_range(9, 0) == 0) return $urandom_range(1, 0) ? cfg_max_valid : 8'(lo);
        return 8'($urandom_range(cfg_max_valid, lo));
    endfunction

    function automatic logic [7:0] pick_invalid();
        int roll;
        if (cfg_max_valid == 8'd255 && !cfg_zero_invalid) return 8'($urandom_range(255, 0));
        roll = $urandom_range(2, 0);
        if (cfg_zero_invalid && (cfg_max_valid == 8'd255 || roll == 0)) return 8'd0;
        if (roll == 1) return 8'(cfg_max_valid + 8'd1);
        return 8'($urandom_range(255, cfg_max_valid + 1));
    endfunction

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (rx_quiet) begin
                m_axis_tready <= 1'b1;
            end else begin
                hold_left = gap_len();
                if (hold_left > 0) begin
                    hold_left--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] max_valid, input logic zero_invalid);
        apb_write(ADDR_MAX_VALID, {24'd0, max_valid});
        apb_write(ADDR_ZERO_INVALID, {31'd0, zero_invalid});
        cfg_max_valid    = max_valid;
        cfg_zero_invalid = zero_invalid;
    endtask

    task automatic send_sample(input logic [7:0] s, input logic fin);
        int idle;
        idle = tx_quiet ? 0 : gap_len();
        if (idle > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_gap(input int len);
        int k;
        for (k = 0; k < len; k++) begin
            send_sample(pick_invalid(), 1'b0);
        end
    endtask

    task automatic send_recording(input int items, input bit close);
        int left;
        int len;
        int k;
        int roll;
        left = items;
        while (left > 0) begin
            roll = $urandom_range(99, 0);
            if (roll < 15) begin
                send_sample(8'($urandom_range(255, 0)), $urandom_range(24, 0) == 0);
                left--;
            end else if (roll < 55) begin
                len = $urandom_range(4, 1);
                for (k = 0; k < len; k++) begin
                    send_sample(pick_valid(), 1'b0);
                end
                left -= len;
            end else begin
                roll = $urandom_range(99, 0);
                if (roll < 70)
                    len = $urandom_range(6, 1);
                else if (roll < 90)
                    len = $urandom_range(MAX_GAP_DEF, 7);
                else
                    len = $urandom_range(MAX_GAP_DEF + 8, MAX_GAP_DEF + 1);
                send_gap(len);
                left -= len;
            end
        end
        if (close) begin
            send_sample($urandom_range(1, 0) ? pick_valid() : pick_invalid(), 1'b1);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        cfg_max_valid    = MAX_VALID_RST;
        cfg_zero_invalid = ZERO_INVALID_RST;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // leading run, boundary values, downward interpolation
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd206, 1'b0);
        send_sample(8'd207, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd10, 1'b0);
        send_sample(8'd1, 1'b0);
        send_sample(8'd200, 1'b0);
        send_sample(8'd100, 1'b0);
        // trailing run ended by an invalid final sample
        send_sample(8'd5, 1'b0);
        send_sample(8'd250, 1'b0);
        send_sample(8'd0, 1'b1);
        // single-beat recordings and a two-sample recording closed by an invalid sample
        send_sample(8'd7, 1'b1);
        send_sample(8'd230, 1'b1);
        send_sample(8'd50, 1'b0);
        send_sample(8'd220, 1'b1);
        // widest spans both ways
        send_sample(8'd1, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd206, 1'b0);
        send_sample(8'd207, 1'b0);
        send_sample(8'd1, 1'b1);
        wait_drained();

        set_config(8'd206, 1'b1);
        send_sample(pick_valid(), 1'b0);
        send_gap(MAX_GAP_DEF + 2);
        send_recording(PHASE_ITEMS, 1'b1);
        wait_drained();

        set_config(8'd255, 1'b1);
        long_hold_req = 1'b1;
        tx_quiet      = 1'b1;
        send_recording(24, 1'b0);
        tx_quiet      = 1'b0;
        send_recording(PHASE_ITEMS, 1'b1);
        wait_drained();

        set_config(8'd120, 1'b0);
        send_recording(PHASE_ITEMS / 2, 1'b0);
        wait_drained();
        send_recording(PHASE_ITEMS / 2, 1'b1);
        wait_drained();

        set_config(8'd0, 1'b0);
        rx_quiet = 1'b1;
        tx_quiet = 1'b1;
        send_recording(PHASE_ITEMS, 1'b1);
        rx_quiet = 1'b0;
        tx_quiet = 1'b0;
        wait_drained();

        set_config(8'd255, 1'b0);
        send_recording(PHASE_ITEMS, 1'b1);
        wait_drained();

        set_config(8'd1, 1'b1);
        send_recording(PHASE_ITEMS, 1'b1);
        wait_drained();

        set_config(8'd0, 1'b1);
        send_recording(12, 1'b1);
        wait_drained();

        set_config(8'd170, 1'b1);
        send_recording(PHASE_ITEMS, 1'b1);
        wait_drained();

        if (mismatches == 0)
            $display("[sensor_gap_interpolator_unit] OK");
        else
            $display("[sensor_gap_interpolator_unit] ERROR");
        $finish;
    end

endmodule

/* sim.f */
src/sgi_pkg.sv
src/sgi_gap_mem.sv
src/sgi_divider.sv
src/sgi_core.sv
src/sensor_gap_interpolator_unit.sv
src/sgi_checker.sv
test/gap_repair_checker.sv
test/tb_sensor_gap_interpolator_unit.sv
